// ===== rtl/prw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prw_pkg
// Shared types and codes for the per-second rate window block.
// ----------------------------------------------------------------------------
package prw_pkg;

	// item operation codes
	typedef enum logic {
		OP_COUNT = 1'b0,
		OP_READ  = 1'b1
	} op_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INC,
		ST_ADV,
		ST_READ
	} state_t;

endpackage
`default_nettype wire

// ===== rtl/prw_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prw_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module prw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 60
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/per_second_rate_window.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// per_second_rate_window
// Sliding window of per-second event counts kept in one RAM ring.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. A count item
// (opcode 0) with a time not after the recorded one adds one to the newest
// slot (saturating) and keeps busy high until the slot, read from the RAM,
// is written back. A count item with a later time walks the ring, one RAM
// write per cycle, clearing each skipped slot and setting the new newest
// slot to one, min(elapsed, WINDOW_SLOTS) slots in all, with busy high
// during the walk. The first count item after reset only records the time
// and does not raise busy. A read item (opcode 1) issues one RAM read per
// cycle over all WINDOW_SLOTS slots, oldest first, with busy high while it
// does; each result passes the RAM read register and the result register,
// then shows on slot_count/is_last with strobe for one cycle. The receiver
// cannot stall: results arrive back to back and must be taken as they come.
// The single RAM port pair sets these rates. Reset clears the window at once
// through one valid flag per slot; no clearing pass is needed.
// ----------------------------------------------------------------------------
module per_second_rate_window #(
	parameter int WINDOW_SLOTS = 60,
	parameter int COUNT_BITS   = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [0:0]  opcode,
	input  wire logic [31:0] now_seconds,
	output logic             strobe,
	output logic [31:0]      slot_count,
	output logic             is_last
);

	localparam int IDX_W = $clog2(WINDOW_SLOTS);
	localparam int CNT_W = $clog2(WINDOW_SLOTS + 1);

	// ring index helper: wraps at the window size
	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
		logic [IDX_W-1:0] n;
		n = (idx == IDX_W'(WINDOW_SLOTS - 1)) ? '0 : idx + 1'b1;
		return n;
	endfunction

	prw_pkg::state_t state_q, state_d;

	logic [IDX_W-1:0]      cur_q;      // newest slot
	logic [31:0]           last_q;     // recorded time
	logic                  started_q;  // window has begun
	logic [IDX_W-1:0]      idx_q;      // walk / read-out pointer
	logic [CNT_W-1:0]      rem_q;      // steps left in the walk or read-out
	logic [WINDOW_SLOTS-1:0] vld_q;    // slot written since reset

	// read pipeline
	logic                  rd_s1;
	logic                  last_s1;
	logic                  vld_s1;

	// ram ports
	logic                  ram_we;
	logic [IDX_W-1:0]      ram_waddr;
	logic [COUNT_BITS-1:0] ram_wdata;
	logic                  ram_re;
	logic [IDX_W-1:0]      ram_raddr;
	logic [COUNT_BITS-1:0] ram_rdata;
	logic [COUNT_BITS-1:0] rd_val;

	logic                  accept;
	logic                  is_read;
	logic [31:0]           gap;
	logic                  gap_big;
	logic [CNT_W-1:0]      gap_steps;
	logic [IDX_W-1:0]      walk_idx;

	assign busy      = (state_q != prw_pkg::ST_IDLE);
	assign accept    = start && !busy;
	assign is_read   = (opcode == prw_pkg::OP_READ);
	assign gap       = now_seconds - last_q;
	assign gap_big   = gap > 32'(WINDOW_SLOTS);
	assign gap_steps = gap_big ? CNT_W'(WINDOW_SLOTS) : CNT_W'(gap);
	assign walk_idx  = next_idx(idx_q);
	// slots never written since reset read as zero
	assign rd_val    = vld_s1 ? ram_rdata : '0;

	prw_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (WINDOW_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// next state and ram control
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = cur_q;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = cur_q;
		case (state_q)
			prw_pkg::ST_IDLE: begin
				if (accept) begin
					if (is_read) begin
						state_d = prw_pkg::ST_READ;
					end else if (started_q) begin
						if (now_seconds <= last_q) begin
							// same or earlier second: fetch the newest slot
							ram_re  = 1'b1;
							state_d = prw_pkg::ST_INC;
						end else begin
							state_d = prw_pkg::ST_ADV;
						end
					end
				end
			end
			prw_pkg::ST_INC: begin
				// saturating read-modify-write of the newest slot
				ram_we    = 1'b1;
				ram_waddr = cur_q;
				ram_wdata = (&rd_val) ? rd_val : rd_val + 1'b1;
				state_d   = prw_pkg::ST_IDLE;
			end
			prw_pkg::ST_ADV: begin
				// clear skipped slots, the final one starts at one
				ram_we    = 1'b1;
				ram_waddr = walk_idx;
				ram_wdata = (rem_q == CNT_W'(1)) ? COUNT_BITS'(1) : '0;
				if (rem_q == CNT_W'(1)) begin
					state_d = prw_pkg::ST_IDLE;
				end
			end
			prw_pkg::ST_READ: begin
				ram_re    = 1'b1;
				ram_raddr = idx_q;
				if (rem_q == CNT_W'(1)) begin
					state_d = prw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = prw_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prw_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// window bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q     <= '0;
			last_q    <= '0;
			started_q <= 1'b0;
			idx_q     <= '0;
			rem_q     <= '0;
			vld_q     <= '0;
		end else begin
			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
			case (state_q)
				prw_pkg::ST_IDLE: begin
					if (accept) begin
						if (is_read) begin
							idx_q <= next_idx(cur_q);
							rem_q <= CNT_W'(WINDOW_SLOTS);
						end else if (!started_q) begin
							started_q <= 1'b1;
							last_q    <= now_seconds;
						end else if (now_seconds > last_q) begin
							idx_q  <= cur_q;
							rem_q  <= gap_steps;
							last_q <= now_seconds;
						end
					end
				end
				prw_pkg::ST_ADV: begin
					idx_q <= walk_idx;
					rem_q <= rem_q - 1'b1;
					if (rem_q == CNT_W'(1)) begin
						cur_q <= walk_idx;
					end
				end
				prw_pkg::ST_READ: begin
					idx_q <= next_idx(idx_q);
					rem_q <= rem_q - 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// read-out pipeline: issue, ram data, result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1   <= 1'b0;
			last_s1 <= 1'b0;
			vld_s1  <= 1'b0;
			strobe  <= 1'b0;
			is_last <= 1'b0;
		end else begin
			rd_s1   <= (state_q == prw_pkg::ST_READ);
			last_s1 <= (state_q == prw_pkg::ST_READ) && (rem_q == CNT_W'(1));
			if (ram_re) begin
				vld_s1 <= vld_q[ram_raddr];
			end
			strobe  <= rd_s1;
			is_last <= rd_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_s1) begin
			slot_count <= 32'(rd_val);
		end
	end

endmodule
`default_nettype wire

// ===== rtl/prw_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prw_checker
// Port-level checks for the per-second rate window, bound to the top level.
// ----------------------------------------------------------------------------
module prw_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic [0:0]  opcode,
	input wire logic        strobe,
	input wire logic        is_last
);

	// is_last only marks a delivered item
	a_last_with_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		is_last |-> strobe)
		else $error("is_last without strobe");

	// a read-out occupies the block
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode == prw_pkg::OP_READ) |=> busy)
		else $error("read item did not raise busy");

	// the end of a run is followed by a gap
	a_run_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && is_last) |=> !strobe)
		else $error("result right after end of run");

	// a count item never produces a result
	a_count_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode == prw_pkg::OP_COUNT) |-> ##2 !strobe)
		else $error("result after count item");

endmodule

bind per_second_rate_window prw_checker u_prw_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.opcode  (opcode),
	.strobe  (strobe),
	.is_last (is_last)
);
`default_nettype wire

// ===== tb/prw_rate_window_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prw_rate_window_checker
// Watches the item and result channels of the rate window block, keeps its
// own copy of the per-second ring, and checks each read-out slot in order.
// ----------------------------------------------------------------------------
module prw_rate_window_checker #(
	parameter int WINDOW_SLOTS = 60
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic [0:0]  opcode,
	input  wire logic [31:0] now_seconds,
	input  wire logic        strobe,
	input  wire logic [31:0] slot_count,
	input  wire logic        is_last,
	output int               errors,
	output int               pending,
	output int               checked
);

	typedef struct packed {
		logic [31:0] count;
		logic        last;
	} slot_result_t;

	logic [31:0]  ring [WINDOW_SLOTS];
	int           newest;
	logic [31:0]  last_sec;
	bit           started;
	slot_result_t readout_q [$];

	function automatic int ring_next(input int idx);
		return (idx + 1 >= WINDOW_SLOTS) ? 0 : idx + 1;
	endfunction

	// one count item against the ring
	task automatic tally_event(input logic [31:0] t);
		logic [31:0] span;
		int idx;
		begin
			idx = newest;
			if (!started) begin
				started  = 1'b1;
				last_sec = t;
			end else if (t <= last_sec) begin
				if (ring[idx] != '1)
					ring[idx] = ring[idx] + 32'd1;
			end else begin
				span = t - last_sec;
				if (span > WINDOW_SLOTS)
					span = WINDOW_SLOTS;
				for (int i = 0; i < span; i++) begin
					idx = ring_next(idx);
					ring[idx] = '0;
				end
				ring[idx] = 32'd1;
				newest    = idx;
				last_sec  = t;
			end
		end
	endtask

	// oldest slot first, newest marked last
	task automatic snapshot_window();
		int idx;
		slot_result_t r;
		begin
			idx = ring_next(newest);
			for (int k = 0; k < WINDOW_SLOTS; k++) begin
				r.count = ring[idx];
				r.last  = (k == WINDOW_SLOTS - 1);
				readout_q.push_back(r);
				idx = ring_next(idx);
			end
		end
	endtask

	task automatic report_mismatch(input string what);
		begin
			$display("mismatch at %0t: %s", $time, what);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		slot_result_t exp_r;
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_SLOTS; i++)
				ring[i] = '0;
			newest   = 0;
			last_sec = '0;
			started  = 1'b0;
			readout_q.delete();
			pending  = 0;
		end else begin
			if (strobe) begin
				if (readout_q.size() == 0) begin
					report_mismatch("slot result with nothing expected");
				end else begin
					exp_r = readout_q.pop_front();
					checked++;
					if (slot_count !== exp_r.count)
						report_mismatch($sformatf("slot_count %0d, expected %0d",
							slot_count, exp_r.count));
					if (is_last !== exp_r.last)
						report_mismatch($sformatf("is_last %b, expected %b",
							is_last, exp_r.last));
				end
			end
			if (start && !busy) begin
				if (prw_pkg::op_t'(opcode) == prw_pkg::OP_READ)
					snapshot_window();
				else
					tally_event(now_seconds);
			end
			pending = readout_q.size();
		end
	end

endmodule
`default_nettype wire

// ===== tb/tb_per_second_rate_window.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_per_second_rate_window
// Stimulus and verdict for the per-second rate window block.
// ----------------------------------------------------------------------------
// A directed opening walks the special cases (read before the window starts,
// the starting count, same and earlier seconds, exact and over-long gaps),
// then three random phases mix count and read items, the first two with idle
// gaps on the item side. A checker beside the block predicts every read-out slot.
// ----------------------------------------------------------------------------
module tb_per_second_rate_window;

	localparam int WINDOW_SLOTS = 60;
	localparam int PHASE_ITEMS  = 120;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [0:0]  opcode;
	logic [31:0] now_seconds;
	logic        strobe;
	logic [31:0] slot_count;
	logic        is_last;

	int errors;
	int pending;
	int checked;

	// stimulus bookkeeping
	logic [31:0] clock_sec;   // latest second handed to the block
	int          idle_pct;    // chance of an idle gap before an item
	int          n_counts;
	int          n_reads;

	// period 12: high 6, low 6
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	per_second_rate_window #(
		.WINDOW_SLOTS(WINDOW_SLOTS),
		.COUNT_BITS  (32)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.opcode     (opcode),
		.now_seconds(now_seconds),
		.strobe     (strobe),
		.slot_count (slot_count),
		.is_last    (is_last)
	);

	prw_rate_window_checker #(
		.WINDOW_SLOTS(WINDOW_SLOTS)
	) checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.opcode     (opcode),
		.now_seconds(now_seconds),
		.strobe     (strobe),
		.slot_count (slot_count),
		.is_last    (is_last),
		.errors     (errors),
		.pending    (pending),
		.checked    (checked)
	);

	// drive one item from a falling edge and hold it until the block takes it;
	// returns at the falling edge after acceptance, start still high
	task automatic issue_item(input prw_pkg::op_t op, input logic [31:0] t);
		int gap;
		begin
			if ($urandom_range(99, 0) < idle_pct) begin
				// mostly short gaps, now and then one long enough to span a read-out
				gap = ($urandom_range(9, 0) == 0) ? $urandom_range(70, 1)
				                                  : $urandom_range(6, 1);
				start <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			start       <= 1'b1;
			opcode      <= op;
			now_seconds <= t;
			// busy sampled at the rising edge: low there means the item was taken
			do @(posedge clk); while (busy);
			@(negedge clk);
			if (op == prw_pkg::OP_READ)
				n_reads++;
			else
				n_counts++;
		end
	endtask

	task automatic count_at(input logic [31:0] t);
		begin
			if (t > clock_sec)
				clock_sec = t;
			issue_item(prw_pkg::OP_COUNT, t);
		end
	endtask

	// hold the item side until every read-out slot has come back
	task automatic drain_readouts();
		begin
			start <= 1'b0;
			@(negedge clk);
			while (pending != 0)
				@(negedge clk);
		end
	endtask

	// one random item: mostly counts near the current second, some reads,
	// some earlier times, now and then a gap that reaches the window cap
	task automatic random_item();
		int r;
		begin
			r = $urandom_range(99, 0);
			if (r < 15)
				issue_item(prw_pkg::OP_READ, $urandom());
			else if (r < 52)
				count_at(clock_sec);
			else if (r < 74)
				count_at(clock_sec + $urandom_range(4, 1));
			else if (r < 82)
				count_at(clock_sec + $urandom_range(70, 5));
			else if (r < 94)
				count_at($urandom_range(clock_sec, 0));
			else
				count_at($urandom() & clock_sec);
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		opcode      = prw_pkg::OP_COUNT;
		now_seconds = '0;
		clock_sec   = '0;
		idle_pct    = 20;
		n_counts    = 0;
		n_reads     = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed opening
		issue_item(prw_pkg::OP_READ, 32'd0);         // window not started: all zero
		count_at(32'd0);                             // starting count, counts nothing
		count_at(32'd0);                             // same second
		count_at(32'd0);
		issue_item(prw_pkg::OP_READ, 32'd0);
		count_at(32'd1);                             // one-second step
		count_at(32'd0);                             // earlier time counts as current
		count_at(32'd3);                             // skip one slot
		count_at(32'd3);
		issue_item(prw_pkg::OP_READ, 32'd0);
		count_at(32'd63);                            // gap equal to the window
		issue_item(prw_pkg::OP_READ, 32'd0);
		count_at(32'd200);                           // gap past the cap
		count_at(32'd200);
		count_at(32'd259);                           // gap one short of the window
		issue_item(prw_pkg::OP_READ, 32'd0);
		count_at(32'hC000_0000);                     // huge jump
		count_at(32'hC000_0001);
		count_at(32'd5);                             // far earlier
		issue_item(prw_pkg::OP_READ, 32'hFFFF_FFFF); // time ignored on reads
		drain_readouts();

		// random phases: item side idles 20%, then 53%, then never
		for (int i = 0; i < PHASE_ITEMS; i++)
			random_item();
		drain_readouts();
		idle_pct = 53;
		for (int i = 0; i < PHASE_ITEMS; i++)
			random_item();
		drain_readouts();
		idle_pct = 0;
		for (int i = 0; i < PHASE_ITEMS; i++)
			random_item();

		// top of the time range last, since nothing can come after it
		count_at(32'hFFFF_FFFF);
		count_at(32'hFFFF_FFFF);
		count_at(32'd0);
		issue_item(prw_pkg::OP_READ, 32'd0);
		drain_readouts();

		// allow any stray result to show
		repeat (WINDOW_SLOTS + 10) @(negedge clk);

		$display("run covered %0d count items and %0d window reads", n_counts, n_reads);
		$display("%0d slot results checked, %0d mismatches", checked, errors);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// run limit, far above the slowest correct run
	initial begin
		#(12 * 600000);
		$display("timeout waiting on the block");
		$display("== FAIL ==");
		$finish;
	end

endmodule
`default_nettype wire
